>>> hw/rtl/dual_track_speed_ramp_top_assert.svh
// assertion macros shared by the speed ramp checker
`ifndef DUAL_TRACK_SPEED_RAMP_TOP_ASSERT_SVH
`define DUAL_TRACK_SPEED_RAMP_TOP_ASSERT_SVH

// antecedent holds in this cycle, consequent checked in the same cycle
`define DTSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent checked in the next cycle
`define DTSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dtsr_pkg.sv
// types and constants for the dual track speed ramp
package dtsr_pkg;

    localparam int SPEED_W   = 9;
    localparam int DUTY_W    = 8;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int LIM_W     = SPEED_W + 1;
    localparam int PROD_W    = 2 * SPEED_W;

    localparam logic [LIM_W-1:0]     LIM_MAX  = LIM_W'((1 << SPEED_W) - 1);
    localparam logic [DUTY_W-1:0]    DUTY_TOP = '1;
    localparam logic [DUTY_W-1:0]    DUTY_ZERO = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 2'd2;

    typedef enum logic [1:0] {
        MODE_STARTUP = 2'd0,
        MODE_HOLDING = 2'd1,
        MODE_RAMPING = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_MUL,
        ST_OUT
    } t_seq;

    typedef struct packed {
        logic latch;   // target beat: origin <= speed, aim <= goal
        logic zero;    // first tick: clear speed, origin and aim
        logic step;    // apply one ramp step
        logic mul;     // register the duty product
    } t_lane_ctl;

endpackage

>>> hw/rtl/dtsr_chan_if.sv
// handshake channels for target/tick beats and duty result beats
interface dtsr_in_if import dtsr_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic signed [SPEED_W-1:0] right_goal;
    logic signed [SPEED_W-1:0] left_goal;

    modport source (output valid, output action, output right_goal, output left_goal,
                    input ready);
    modport sink   (input valid, input action, input right_goal, input left_goal,
                    output ready);
endinterface

interface dtsr_out_if import dtsr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] right_duty;
    logic              right_reverse;
    logic [DUTY_W-1:0] left_duty;
    logic              left_reverse;
    logic              ramping;

    modport source (output valid, output right_duty, output right_reverse,
                    output left_duty, output left_reverse, output ramping, input ready);
    modport sink   (input valid, input right_duty, input right_reverse,
                    input left_duty, input left_reverse, input ramping, output ready);
endinterface

>>> hw/rtl/dtsr_div.sv
// restoring divider, one quotient bit per cycle
module dtsr_div import dtsr_pkg::*; #(
    parameter int ELAPSED_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ELAPSED_WIDTH-1:0] i_dividend,
    input  logic [MS_W-1:0]          i_divisor,
    output logic                     o_done,
    output logic [ELAPSED_WIDTH-1:0] o_quot
);

    localparam int CNT_W = $clog2(ELAPSED_WIDTH + 1);

    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [MS_W-1:0]          r_rem, n_rem;
    logic [MS_W-1:0]          r_div;
    logic [ELAPSED_WIDTH-1:0] r_quo, n_quo;
    logic [MS_W:0]            w_shift;
    logic [MS_W:0]            w_diff;

    assign w_shift = {r_rem, r_quo[ELAPSED_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_cnt  = CNT_W'(ELAPSED_WIDTH);
            n_busy = 1'b1;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_div}) begin
                n_rem = w_diff[MS_W-1:0];
                n_quo = {r_quo[ELAPSED_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = w_shift[MS_W-1:0];
                n_quo = {r_quo[ELAPSED_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> hw/rtl/dtsr_lane.sv
// one track lane: ramp step toward the aim and speed to duty mapping
module dtsr_lane import dtsr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_ctl                 i_ctl,
    input  logic signed [SPEED_W-1:0] i_goal,
    input  logic [LIM_W-1:0]          i_lim,
    input  logic [DUTY_W-1:0]         i_min_duty,
    input  logic [DUTY_W-1:0]         i_max_duty,
    output logic                      o_at_aim,
    output logic [DUTY_W-1:0]         o_duty,
    output logic                      o_reverse
);

    logic signed [SPEED_W-1:0] r_speed, r_origin, r_aim;
    logic signed [SPEED_W-1:0] n_speed;
    logic signed [SPEED_W+1:0] w_diff, w_lim, w_delta, w_sum;
    logic [SPEED_W-1:0]        w_mag;
    logic signed [DUTY_W:0]    w_span;
    logic signed [PROD_W-1:0]  w_prod, r_prod, w_pneg;
    logic [PROD_W-2:0]         w_pmag;
    logic [PROD_W-1:0]         w_qsum;
    logic [SPEED_W:0]          w_quot;
    logic signed [DUTY_W+2:0]  w_sq, w_d;
    logic [DUTY_W-1:0]         w_sat;

    // clamp (aim - origin) to +/- lim
    always_comb begin
        w_diff = $signed({{2{r_aim[SPEED_W-1]}}, r_aim})
               - $signed({{2{r_origin[SPEED_W-1]}}, r_origin});
        w_lim  = $signed({1'b0, i_lim});
        if (w_diff > w_lim) begin
            w_delta = w_lim;
        end else if (w_diff < -w_lim) begin
            w_delta = -w_lim;
        end else begin
            w_delta = w_diff;
        end
        w_sum   = $signed({{2{r_origin[SPEED_W-1]}}, r_origin}) + w_delta;
        n_speed = w_sum[SPEED_W-1:0];
    end

    assign o_at_aim = (n_speed == r_aim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= '0;
            r_origin <= '0;
            r_aim    <= '0;
        end else if (i_ctl.zero) begin
            r_speed  <= '0;
            r_origin <= '0;
            r_aim    <= '0;
        end else if (i_ctl.latch) begin
            r_origin <= r_speed;
            r_aim    <= i_goal;
        end else if (i_ctl.step) begin
            r_speed  <= n_speed;
        end
    end

    // magnitude times duty span
    assign w_mag  = r_speed[SPEED_W-1] ? (~r_speed + 1'b1) : r_speed;
    assign w_span = $signed({1'b0, i_max_duty}) - $signed({1'b0, i_min_duty});
    assign w_prod = PROD_W'($signed({1'b0, w_mag})) * PROD_W'(w_span);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= w_prod;
        end
    end

    // divide by 255 toward zero: (x + x/256 + 1) / 256 for x below 65535
    always_comb begin
        w_pneg = -r_prod;
        w_pmag = r_prod[PROD_W-1] ? w_pneg[PROD_W-2:0] : r_prod[PROD_W-2:0];
        w_qsum = {1'b0, w_pmag} + PROD_W'(w_pmag[PROD_W-2:8]) + PROD_W'(1);
        w_quot = w_qsum[PROD_W-1:8];
        w_sq   = r_prod[PROD_W-1] ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        w_d    = w_sq + $signed({3'b000, i_min_duty});
        if (w_d < 0) begin
            w_sat = DUTY_ZERO;
        end else if (w_d > $signed({3'b000, DUTY_TOP})) begin
            w_sat = DUTY_TOP;
        end else begin
            w_sat = w_d[DUTY_W-1:0];
        end
    end

    assign o_duty    = (r_speed == '0) ? DUTY_ZERO : w_sat;
    assign o_reverse = r_speed[SPEED_W-1];

endmodule

>>> hw/rtl/dual_track_speed_ramp_top.sv
// two track speed ramp: slew limited speeds mapped to pwm duty
//
//  channel  dir  beat                                     handshake
//  i_in     in   action, right_goal, left_goal            valid/ready
//  o_out    out  right/left duty and reverse, ramping      valid/ready
//  i_cfg_*  in   register index and write data            write enable only
//
// one beat at a time: a target beat or a tick outside ramping goes from accept
// through the mul and out steps into the output register; a ramping tick first
// runs the bit-serial elapsed / ms_per_step divider shared by both lanes and
// then the step state.
// the result sits in an output register, so the next beat is taken while it
// waits; a result that cannot leave holds the sequencer in its last step.
// synchronous active-low reset puts the block in startup with zero speeds.
module dual_track_speed_ramp_top import dtsr_pkg::*; #(
    parameter int ELAPSED_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dtsr_in_if.sink              i_in,
    dtsr_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int QW = (ELAPSED_WIDTH > LIM_W) ? ELAPSED_WIDTH : LIM_W;

    t_seq                     r_state, n_state;
    t_mode                    r_mode, n_mode;
    logic [ELAPSED_WIDTH-1:0] r_elapsed, n_elapsed, w_elapsed_inc;
    logic [MS_W-1:0]          r_ms_per_step;
    logic [DUTY_W-1:0]        r_min_duty, r_max_duty;

    logic                     w_accept, w_in_ready, w_out_free, w_load_out;
    logic                     w_div_start, w_div_done;
    logic [ELAPSED_WIDTH-1:0] w_quot;
    logic [QW-1:0]            w_quot_ext;
    logic [LIM_W-1:0]         w_lim;
    logic [MS_W-1:0]          w_divisor;
    t_lane_ctl                w_lane_ctl;

    logic                     w_r_at_aim, w_l_at_aim;
    logic [DUTY_W-1:0]        w_r_duty, w_l_duty;
    logic                     w_r_rev, w_l_rev;

    logic                     r_out_valid;
    logic [DUTY_W-1:0]        r_out_r_duty, r_out_l_duty;
    logic                     r_out_r_rev, r_out_l_rev, r_out_ramping;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_per_step <= MS_W'(1);
            r_min_duty    <= DUTY_ZERO;
            r_max_duty    <= DUTY_TOP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MS_PER_STEP: r_ms_per_step <= i_cfg_wdata[MS_W-1:0];
                CFG_MIN_DUTY:    r_min_duty    <= i_cfg_wdata[DUTY_W-1:0];
                CFG_MAX_DUTY:    r_max_duty    <= i_cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free    = !r_out_valid || o_out.ready;
    assign w_accept      = i_in.valid && w_in_ready;
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_divisor     = (r_ms_per_step == '0) ? MS_W'(1) : r_ms_per_step;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!i_in.action && r_mode == MODE_RAMPING) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_ready       = 1'b0;
        w_lane_ctl       = '0;
        w_div_start      = 1'b0;
        w_load_out       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready       = 1'b1;
                w_lane_ctl.latch = i_in.valid && i_in.action && r_mode != MODE_STARTUP;
                w_lane_ctl.zero  = i_in.valid && !i_in.action && r_mode == MODE_STARTUP;
                w_div_start      = i_in.valid && !i_in.action && r_mode == MODE_RAMPING;
            end
            ST_STEP: w_lane_ctl.step = 1'b1;
            ST_MUL:  w_lane_ctl.mul  = 1'b1;
            ST_OUT:  w_load_out      = w_out_free;
            default: ;
        endcase
    end

    // mode and elapsed count
    always_comb begin
        n_mode    = r_mode;
        n_elapsed = r_elapsed;
        if (w_accept) begin
            if (i_in.action) begin
                if (r_mode != MODE_STARTUP) begin
                    n_mode    = MODE_RAMPING;
                    n_elapsed = '0;
                end
            end else if (r_mode == MODE_STARTUP) begin
                n_mode = MODE_HOLDING;
            end else if (r_mode == MODE_RAMPING) begin
                n_elapsed = w_elapsed_inc;
            end
        end else if (r_state == ST_STEP && w_r_at_aim && w_l_at_aim) begin
            n_mode = MODE_HOLDING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= MODE_STARTUP;
            r_elapsed <= '0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
        end
    end

    dtsr_div #(
        .ELAPSED_WIDTH(ELAPSED_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_elapsed_inc),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // any step of 511 or more reaches every aim
    assign w_quot_ext = QW'(w_quot);
    assign w_lim      = (w_quot_ext > QW'(LIM_MAX)) ? LIM_MAX : w_quot_ext[LIM_W-1:0];

    dtsr_lane u_lane_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_lane_ctl),
        .i_goal     (i_in.right_goal),
        .i_lim      (w_lim),
        .i_min_duty (r_min_duty),
        .i_max_duty (r_max_duty),
        .o_at_aim   (w_r_at_aim),
        .o_duty     (w_r_duty),
        .o_reverse  (w_r_rev)
    );

    dtsr_lane u_lane_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_lane_ctl),
        .i_goal     (i_in.left_goal),
        .i_lim      (w_lim),
        .i_min_duty (r_min_duty),
        .i_max_duty (r_max_duty),
        .o_at_aim   (w_l_at_aim),
        .o_duty     (w_l_duty),
        .o_reverse  (w_l_rev)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_r_duty  <= w_r_duty;
            r_out_r_rev   <= w_r_rev;
            r_out_l_duty  <= w_l_duty;
            r_out_l_rev   <= w_l_rev;
            r_out_ramping <= (r_mode == MODE_RAMPING);
        end
    end

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.right_duty    = r_out_r_duty;
    assign o_out.right_reverse = r_out_r_rev;
    assign o_out.left_duty     = r_out_l_duty;
    assign o_out.left_reverse  = r_out_l_rev;
    assign o_out.ramping       = r_out_ramping;

endmodule

>>> hw/rtl/dtsr_chk.sv
// port checker for the speed ramp, bound to the top level
`include "dual_track_speed_ramp_top_assert.svh"

module dtsr_chk import dtsr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DUTY_W-1:0] i_out_r_duty,
    input logic [DUTY_W-1:0] i_out_l_duty,
    input logic              i_out_ramping
);

    // a stalled result beat keeps its payload
    `DTSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_r_duty) && $stable(i_out_l_duty) && $stable(i_out_ramping), "stalled result changed")

    // only one beat in work at a time
    `DTSR_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken while a beat is in work")

    // a fresh result appears only at the end of work on a beat
    `DTSR_ASSERT_SAME(a_result_source, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result appeared without a beat in work")

endmodule

bind dual_track_speed_ramp_top dtsr_chk u_dtsr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_r_duty  (o_out.right_duty),
    .i_out_l_duty  (o_out.left_duty),
    .i_out_ramping (o_out.ramping)
);

>>> test/dual_track_speed_ramp_top_test.sv
// self-checking testbench for the dual track speed ramp: random ramps, duty mapping, stalls
module dual_track_speed_ramp_top_test;
    import dtsr_pkg::*;

    localparam int ELAPSED_W     = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLDOFF_LEN   = 400;
    localparam int MAX_REPORTS   = 10;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_TARGET = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [SPEED_W-1:0] right_goal;
        logic signed [SPEED_W-1:0] left_goal;
    } t_track_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0] right_duty;
        logic              right_reverse;
        logic [DUTY_W-1:0] left_duty;
        logic              left_reverse;
        logic              ramping;
    } t_duty_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    dtsr_in_if  in_ch ();
    dtsr_out_if out_ch ();

    dual_track_speed_ramp_top #(
        .ELAPSED_WIDTH(ELAPSED_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    // predicted block state and register copies
    t_mode                     track_mode;
    logic signed [SPEED_W-1:0] right_spd, left_spd;
    logic signed [SPEED_W-1:0] right_org, left_org;
    logic signed [SPEED_W-1:0] right_aim, left_aim;
    logic [ELAPSED_W-1:0]      elapsed_ms;
    logic [MS_W-1:0]           ms_per_step_cfg;
    logic [DUTY_W-1:0]         min_duty_cfg;
    logic [DUTY_W-1:0]         max_duty_cfg;

    t_track_cmd pending_cmds[$];
    t_duty_beat expected_duties[$];
    int         mismatch_cnt;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         in_fired;
    bit         hold_armed;
    bit         hold_done;
    int         hold_left;

    function automatic logic signed [SPEED_W-1:0] slew(input logic signed [SPEED_W-1:0] from,
                                                       input logic signed [SPEED_W-1:0] to,
                                                       input int lim);
        int d;
        d = int'(to) - int'(from);
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return SPEED_W'(int'(from) + d);
    endfunction

    function automatic logic [DUTY_W-1:0] map_duty(input logic signed [SPEED_W-1:0] spd);
        int m;
        int d;
        m = (spd < 0) ? -int'(spd) : int'(spd);
        if (m == 0) return DUTY_ZERO;
        d = m * (int'(max_duty_cfg) - int'(min_duty_cfg)) / 255 + int'(min_duty_cfg);
        if (d < 0) d = 0;
        if (d > 255) d = 255;
        return DUTY_W'(d);
    endfunction

    // applies one command to the predicted state, returns the duty beat it yields
    function automatic t_duty_beat advance_tracks(input t_track_cmd cmd);
        t_duty_beat res;
        int         lim;
        if (cmd.action == ACT_TARGET) begin
            if (track_mode != MODE_STARTUP) begin
                right_org  = right_spd;
                left_org   = left_spd;
                right_aim  = cmd.right_goal;
                left_aim   = cmd.left_goal;
                elapsed_ms = '0;
                track_mode = MODE_RAMPING;
            end
        end else if (track_mode == MODE_STARTUP) begin
            right_spd  = '0;
            left_spd   = '0;
            right_org  = '0;
            left_org   = '0;
            right_aim  = '0;
            left_aim   = '0;
            track_mode = MODE_HOLDING;
        end else if (track_mode == MODE_RAMPING) begin
            if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
            // a zero step period counts as one
            lim = int'(elapsed_ms / ((ms_per_step_cfg == '0) ? MS_W'(1) : ms_per_step_cfg));
            right_spd = slew(right_org, right_aim, lim);
            left_spd  = slew(left_org, left_aim, lim);
            if (right_spd == right_aim && left_spd == left_aim) track_mode = MODE_HOLDING;
        end
        res.right_duty    = map_duty(right_spd);
        res.right_reverse = right_spd < 0;
        res.left_duty     = map_duty(left_spd);
        res.left_reverse  = left_spd < 0;
        res.ramping       = track_mode == MODE_RAMPING;
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // input driver: changes at the falling edge, fed from the pending queue
    always @(negedge i_clk) begin
        t_track_cmd nxt;
        if (!in_ch.valid || in_fired) begin
            if (i_rst_n && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_cmds.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.action     <= nxt.action;
                in_ch.right_goal <= nxt.right_goal;
                in_ch.left_goal  <= nxt.left_goal;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_left = HOLDOFF_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // monitor: predicts on accepted commands, checks accepted duty beats
    always @(posedge i_clk) begin
        t_duty_beat got;
        t_duty_beat exp_beat;
        in_fired = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_fired)
            expected_duties.push_back(advance_tracks({in_ch.action, in_ch.right_goal,
                                                      in_ch.left_goal}));
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.right_duty, out_ch.right_reverse, out_ch.left_duty,
                   out_ch.left_reverse, out_ch.ramping};
            if (expected_duties.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected duty beat: rd=%0d rr=%0b ld=%0d lr=%0b ramp=%0b",
                             got.right_duty, got.right_reverse, got.left_duty,
                             got.left_reverse, got.ramping);
            end else begin
                exp_beat = expected_duties.pop_front();
                if (got !== exp_beat) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("duty beat mismatch: exp rd=%0d rr=%0b ld=%0d lr=%0b ramp=%0b",
                                 exp_beat.right_duty, exp_beat.right_reverse,
                                 exp_beat.left_duty, exp_beat.left_reverse, exp_beat.ramping,
                                 " got rd=%0d rr=%0b ld=%0d lr=%0b ramp=%0b",
                                 got.right_duty, got.right_reverse, got.left_duty,
                                 got.left_reverse, got.ramping);
                end
            end
        end
    end

    task automatic push_cmd(input logic act, input int rg, input int lg);
        t_track_cmd cmd;
        cmd.action     = act;
        cmd.right_goal = SPEED_W'(rg);
        cmd.left_goal  = SPEED_W'(lg);
        pending_cmds.push_back(cmd);
    endtask

    task automatic push_ticks(input int count);
        for (int i = 0; i < count; i++) push_cmd(ACT_TICK, $urandom, $urandom);
    endtask

    // mostly target beats followed by tick runs, with some stray beats mixed in
    task automatic add_random_ramps(input int count);
        int added;
        int ticks;
        int rg;
        int lg;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 70) begin
                    rg = int'($urandom_range(96)) - 48;
                    lg = int'($urandom_range(96)) - 48;
                end else begin
                    rg = $urandom;
                    lg = $urandom;
                end
                push_cmd(ACT_TARGET, rg, lg);
                added = added + 1;
                ticks = ($urandom_range(7) == 0) ? $urandom_range(120, 300)
                                                 : $urandom_range(0, 40);
                if (ticks > count - added) ticks = count - added;
                push_ticks(ticks);
                added = added + ticks;
            end else begin
                push_cmd(1'($urandom_range(1)), $urandom, $urandom);
                added = added + 1;
            end
        end
    endtask

    // waits until every command is taken and every beat checked, then lets the block go idle
    task automatic settle();
        while (pending_cmds.size() != 0 || in_ch.valid || expected_duties.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = value;
        case (idx)
            CFG_MS_PER_STEP: ms_per_step_cfg = value[MS_W-1:0];
            CFG_MIN_DUTY:    min_duty_cfg    = value[DUTY_W-1:0];
            CFG_MAX_DUTY:    max_duty_cfg    = value[DUTY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic start_phase(input int ms, input int min_d, input int max_d,
                               input int send_pct, input int recv_pct);
        settle();
        write_reg(CFG_MS_PER_STEP, CFG_W'(ms));
        write_reg(CFG_MIN_DUTY, CFG_W'(min_d));
        write_reg(CFG_MAX_DUTY, CFG_W'(max_d));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_TICK;
        in_ch.right_goal = '0;
        in_ch.left_goal  = '0;
        out_ch.ready     = 1'b0;
        in_fired         = 1'b0;
        hold_armed       = 1'b0;
        hold_done        = 1'b0;
        hold_left        = 0;
        mismatch_cnt     = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        track_mode       = MODE_STARTUP;
        right_spd        = '0;
        left_spd         = '0;
        right_org        = '0;
        left_org         = '0;
        right_aim        = '0;
        left_aim         = '0;
        elapsed_ms       = '0;
        ms_per_step_cfg  = MS_W'(1);
        min_duty_cfg     = DUTY_ZERO;
        max_duty_cfg     = DUTY_TOP;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        start_phase(1, 0, 255, 8, 85);
        push_cmd(ACT_TARGET, 7, -7);      // ignored in startup
        push_cmd(ACT_TICK, 0, 0);         // startup tick clears and holds
        push_cmd(ACT_TICK, 0, 0);         // tick while holding
        push_cmd(ACT_TARGET, 3, -2);
        push_ticks(3);
        push_cmd(ACT_TARGET, 255, -255);
        push_ticks(4);
        push_cmd(ACT_TARGET, 0, 0);       // retarget mid-ramp
        push_ticks(4);
        push_cmd(ACT_TARGET, 'h155, 'h0AA);
        push_ticks(3);
        push_cmd(ACT_TARGET, -1, 1);
        push_ticks(3);
        // full sweep to the most negative goal; magnitude 256 saturates the duty
        push_cmd(ACT_TARGET, -256, 255);
        push_ticks(258);
        add_random_ramps(150);

        // reversed duty range, zero step period
        start_phase(0, 0, 0, 8, 85);
        settle();
        push_cmd(ACT_TARGET, -256, 255);
        push_ticks(300);
        settle();
        write_reg(CFG_MIN_DUTY, CFG_W'(255));
        push_ticks(2);
        add_random_ramps(100);

        // huge step period: the allowed step stays at zero
        start_phase(65535, 100, 200, 85, 8);
        push_ticks(1);
        push_cmd(ACT_TARGET, 200, -200);
        push_ticks(60);

        start_phase(2, 40, 30, 85, 8);
        add_random_ramps(150);

        // no idling; the receiver holds off once so the block backs up
        start_phase(1, 0, 255, 0, 0);
        hold_armed = 1'b1;
        add_random_ramps(200);

        start_phase(3, 1, 254, 0, 0);
        add_random_ramps(50);

        settle();
        if (mismatch_cnt == 0 && expected_duties.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
